[src/nearest_palette_color_match_defines.svh]
// Assertion macros for the nearest palette color match block.
// Included by the top level; depends on nothing else.
`ifndef NEAREST_PALETTE_COLOR_MATCH_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_MATCH_DEFINES_SVH

// same-cycle implication, held off during reset
`define NPCM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define NPCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/npcm_pkg.sv]
// Shared types and constants for the nearest palette color match block.
// Used by the controller, the datapath and the top level.
package npcm_pkg;

  localparam int unsigned PaletteDepthDef = 256;
  localparam int unsigned PlaneCountW     = 4;
  localparam logic [PlaneCountW-1:0] PlaneCountRst = 4'd8;
  localparam logic [PlaneCountW-1:0] PlaneCountMax = 4'd9;
  localparam logic [23:0] DirectPrefix    = 24'hFFFFFF;
  localparam int unsigned ErrW            = 10;
  localparam logic [ErrW-1:0] ErrInit     = '1;
  localparam logic [0:0] OpLoad           = 1'b0;
  localparam logic [0:0] OpQuery          = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD_SCALE,
    S_LOAD_WRITE,
    S_DIRECT_READ,
    S_DIRECT_CAP,
    S_SCAN,
    S_DRAIN1,
    S_DRAIN2,
    S_EMIT
  } npcm_state_e;

  typedef struct packed {
    logic cap;
    logic ld_scale;
    logic ld_write;
    logic rd_scan;
    logic rd_direct;
    logic direct_cap;
    logic out_load;
  } npcm_cmd_t;

  typedef struct packed {
    logic in_is_load;
    logic in_is_direct;
    logic scan_last;
  } npcm_stat_t;

endpackage

[src/nearest_palette_color_match.sv]
// Top level of the nearest palette color match block.
// Depends on npcm_pkg, npcm_ctrl, npcm_dpath and the assertion macro header.
//
// Use: a word on the input channel (valid/stall) either loads one palette
// entry (op 0) or queries a color (op 1). A load scales the three permille
// intensities to 0..255 and writes the entry with its saturation; it gives
// no result. A query whose color word has the upper 24 bits all ones returns
// that low byte as the index with the stored RGB, or zero RGB if the index
// is beyond the depth. Any other query scans N = min(2^min(plane_count, 9),
// depth) entries through one memory read port, one entry a cycle, then
// drains a two-stage compare pipeline. One item is worked on at a time;
// in_stall_o is high from accept until the item is finished. A finished
// result sits in the output register while out_stall_i is high; the next
// item is accepted meanwhile, and a later result waits for it. Reset clears
// the control and sets plane_count to 8; palette contents are undefined
// until loaded. plane_count is written through the cfg channel; the user
// must write it only while the block is idle, which the block itself does
// not enforce.
module nearest_palette_color_match #(
  parameter int unsigned PALETTE_DEPTH = npcm_pkg::PaletteDepthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [npcm_pkg::PlaneCountW-1:0] cfg_plane_count_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             op_i,
  input  logic [7:0]                       entry_index_i,
  input  logic [9:0]                       permille_red_i,
  input  logic [9:0]                       permille_green_i,
  input  logic [9:0]                       permille_blue_i,
  input  logic [31:0]                      color_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [7:0]                       best_index_o,
  output logic [7:0]                       match_red_o,
  output logic [7:0]                       match_green_o,
  output logic [7:0]                       match_blue_o
);
  import npcm_pkg::*;

  `include "nearest_palette_color_match_defines.svh"

  npcm_cmd_t  cmd;
  npcm_stat_t stat;
  logic       in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;

  npcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  npcm_dpath #(
    .PaletteDepth (PALETTE_DEPTH)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i && cfg_ready_o),
    .cfg_plane_count_i (cfg_plane_count_i),
    .op_i              (op_i),
    .entry_index_i     (entry_index_i),
    .permille_red_i    (permille_red_i),
    .permille_green_i  (permille_green_i),
    .permille_blue_i   (permille_blue_i),
    .color_word_i      (color_word_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .best_index_o      (best_index_o),
    .match_red_o       (match_red_o),
    .match_green_o     (match_green_o),
    .match_blue_o      (match_blue_o)
  );

  `NPCM_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, in_stall_o, "accepted word did not stall input")
  `NPCM_ASSERT_NEXT(a_load_no_result, clk_i, rst_ni, in_acc && (op_i == OpLoad) && !out_valid_o, !out_valid_o, "load produced a result")
  `NPCM_ASSERT_NOW(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result appeared without work in flight")

endmodule

[src/npcm_ctrl.sv]
// Sequencing state machine for the nearest palette color match block.
// Depends on npcm_pkg; drives npcm_dpath through command and status structs.
module npcm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  npcm_pkg::npcm_stat_t stat_i,
  output npcm_pkg::npcm_cmd_t  cmd_o
);
  import npcm_pkg::*;

  npcm_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          if (stat_i.in_is_load) begin
            state_d = S_LOAD_SCALE;
          end else if (stat_i.in_is_direct) begin
            state_d = S_DIRECT_READ;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_LOAD_SCALE: begin
        cmd_o.ld_scale = 1'b1;
        state_d        = S_LOAD_WRITE;
      end
      S_LOAD_WRITE: begin
        cmd_o.ld_write = 1'b1;
        state_d        = S_IDLE;
      end
      S_DIRECT_READ: begin
        cmd_o.rd_direct = 1'b1;
        state_d         = S_DIRECT_CAP;
      end
      S_DIRECT_CAP: begin
        cmd_o.direct_cap = 1'b1;
        state_d          = S_EMIT;
      end
      S_SCAN: begin
        cmd_o.rd_scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DRAIN1;
        end
      end
      S_DRAIN1: state_d = S_DRAIN2;
      S_DRAIN2: state_d = S_EMIT;
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[src/npcm_dpath.sv]
// Datapath: palette memory, permille scaling, scan pipeline and result register.
// Depends on npcm_pkg; controlled by npcm_ctrl.
module npcm_dpath #(
  parameter int unsigned PaletteDepth = npcm_pkg::PaletteDepthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [npcm_pkg::PlaneCountW-1:0]    cfg_plane_count_i,
  input  logic                                op_i,
  input  logic [7:0]                          entry_index_i,
  input  logic [9:0]                          permille_red_i,
  input  logic [9:0]                          permille_green_i,
  input  logic [9:0]                          permille_blue_i,
  input  logic [31:0]                         color_word_i,
  input  npcm_pkg::npcm_cmd_t                 cmd_i,
  output npcm_pkg::npcm_stat_t                stat_o,
  output logic [7:0]                          best_index_o,
  output logic [7:0]                          match_red_o,
  output logic [7:0]                          match_green_o,
  output logic [7:0]                          match_blue_o
);
  import npcm_pkg::*;

  localparam int unsigned AddrW = (PaletteDepth > 1) ? $clog2(PaletteDepth) : 1;
  localparam logic [18:0] RecipM = 19'd268436;

  function automatic logic [7:0] scale_pm(input logic [9:0] c);
    logic [17:0] x;
    logic [36:0] prod;
    logic [8:0]  q;
    x    = ({c, 8'd0} - {8'd0, c}) + 18'd500;
    prod = 37'(x) * 37'(RecipM);
    q    = prod[36:28];
    scale_pm = (q > 9'd255) ? 8'hFF : q[7:0];
  endfunction

  function automatic logic [7:0] sat_of(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    logic [7:0] hi, lo;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    sat_of = hi - lo;
  endfunction

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    absdiff = (a > b) ? a - b : b - a;
  endfunction

  logic [31:0] mem [PaletteDepth];
  logic [31:0] rdata_q;

  logic [PlaneCountW-1:0] plane_count_q;
  logic [7:0]  idx_q;
  logic [9:0]  pr_q, pg_q, pb_q;
  logic [31:0] word_q;
  logic [7:0]  qsat_q;
  logic [7:0]  lr_q, lg_q, lb_q;
  logic [AddrW-1:0] cnt_q, last_q;

  logic             s1_vld_q;
  logic [AddrW-1:0] s1_idx_q;
  logic             s2_vld_q;
  logic             s2_eq_q;
  logic [ErrW-1:0]  s2_err_q;
  logic [AddrW-1:0] s2_idx_q;
  logic [23:0]      s2_rgb_q;

  logic            found_q;
  logic [ErrW-1:0] min_err_q;
  logic [7:0]      best_idx_q;
  logic [23:0]     best_rgb_q;
  logic [7:0]      out_idx_q;
  logic [23:0]     out_rgb_q;

  logic [3:0]       lg2;
  logic [9:0]       count;
  logic [9:0]       last_w;
  logic             rd_en;
  logic [AddrW-1:0] raddr;
  logic [ErrW-1:0]  err;
  logic             eq;
  logic             idx_in_range;

  assign stat_o.in_is_load   = (op_i == OpLoad);
  assign stat_o.in_is_direct = (color_word_i[31:8] == DirectPrefix);
  assign stat_o.scan_last    = (cnt_q == last_q);

  always_comb begin
    lg2    = (plane_count_q > PlaneCountMax) ? PlaneCountMax : plane_count_q;
    count  = 10'd1 << lg2;
    last_w = (count > 10'(PaletteDepth)) ? 10'(PaletteDepth - 1) : count - 10'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_count_q <= PlaneCountRst;
    end else if (cfg_valid_i) begin
      plane_count_q <= cfg_plane_count_i;
    end
  end

  // capture the word and the scan setup
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      idx_q  <= entry_index_i;
      pr_q   <= permille_red_i;
      pg_q   <= permille_green_i;
      pb_q   <= permille_blue_i;
      word_q <= color_word_i;
      qsat_q <= sat_of(color_word_i[23:16], color_word_i[15:8], color_word_i[7:0]);
      last_q <= last_w[AddrW-1:0];
    end
    if (cmd_i.ld_scale) begin
      lr_q <= scale_pm(pr_q);
      lg_q <= scale_pm(pg_q);
      lb_q <= scale_pm(pb_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cap) begin
      cnt_q <= '0;
    end else if (cmd_i.rd_scan) begin
      cnt_q <= cnt_q + AddrW'(1);
    end
  end

  assign idx_in_range = ({1'b0, idx_q} < 9'(PaletteDepth));
  assign rd_en        = cmd_i.rd_scan || cmd_i.rd_direct;
  assign raddr        = cmd_i.rd_direct ? word_q[AddrW-1:0] : cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_write && idx_in_range) begin
      mem[idx_q[AddrW-1:0]] <= {sat_of(lr_q, lg_q, lb_q), lr_q, lg_q, lb_q};
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_comb begin
    eq  = (rdata_q == {qsat_q, word_q[23:0]});
    err = ErrW'(absdiff(word_q[23:16], rdata_q[23:16]))
        + ErrW'(absdiff(word_q[15:8], rdata_q[15:8]))
        + ErrW'(absdiff(word_q[7:0], rdata_q[7:0]))
        + ErrW'(absdiff(qsat_q, rdata_q[31:24]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.rd_scan;
      s2_vld_q <= s1_vld_q;
      if (cmd_i.cap) begin
        found_q <= 1'b0;
      end else if (s2_vld_q && s2_eq_q) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= cnt_q;
    s2_eq_q  <= eq;
    s2_err_q <= err;
    s2_idx_q <= s1_idx_q;
    s2_rgb_q <= rdata_q[23:0];
    if (cmd_i.cap) begin
      min_err_q  <= ErrInit;
      best_idx_q <= '0;
    end else if (cmd_i.direct_cap) begin
      best_idx_q <= word_q[7:0];
      best_rgb_q <= ({1'b0, word_q[7:0]} < 9'(PaletteDepth)) ? rdata_q[23:0] : '0;
    end else if (s2_vld_q && !found_q) begin
      if (s2_eq_q || (s2_err_q <= min_err_q)) begin
        min_err_q  <= s2_err_q;
        best_idx_q <= 8'(s2_idx_q);
        best_rgb_q <= s2_rgb_q;
      end
    end
    if (cmd_i.out_load) begin
      out_idx_q <= best_idx_q;
      out_rgb_q <= best_rgb_q;
    end
  end

  assign best_index_o  = out_idx_q;
  assign match_red_o   = out_rgb_q[23:16];
  assign match_green_o = out_rgb_q[15:8];
  assign match_blue_o  = out_rgb_q[7:0];

endmodule
